FILE: rtl/wsg_pkg.sv
package wsg_pkg;

  // Wave shape selector codes; codes five to seven give a flat DC output.
  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_SQUARE   = 3'd1;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
  localparam logic [2:0] WAVE_SAW      = 3'd3;
  localparam logic [2:0] WAVE_INV_SAW  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_WAVE_TYPE    = 3'd0;
  localparam logic [2:0] REG_PHASE_STEP   = 3'd1;
  localparam logic [2:0] REG_PHASE_SHIFT  = 3'd2;
  localparam logic [2:0] REG_AMPLITUDE    = 3'd3;
  localparam logic [2:0] REG_DC_OFFSET    = 3'd4;
  localparam logic [2:0] REG_DUTY         = 3'd5;

  // Register widths and reset values.
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned AMP_W   = 13;
  localparam int unsigned DC_W    = 15;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned OUT_W   = 15;
  localparam int unsigned CFG_W   = 16;

  localparam logic [2:0]        RST_WAVE_TYPE = WAVE_SINE;
  localparam logic [STEP_W-1:0] RST_STEP      = 16'd655;
  localparam logic [STEP_W-1:0] RST_OFFSET    = 16'd0;
  localparam logic [AMP_W-1:0]  RST_AMP       = 13'd1000;
  localparam logic [DC_W-1:0]   RST_DC        = 15'd2500;
  localparam logic [DUTY_W-1:0] RST_DUTY      = 7'd50;

  // Square duty is given in percent of a period.
  localparam int unsigned PERCENT_SCALE = 100;

  // Output limits in millivolts, held at the width of the final sum.
  localparam int unsigned SUM_W = 17;
  localparam logic signed [SUM_W-1:0] OUT_MAX_MV = 17'sd15000;
  localparam logic signed [SUM_W-1:0] OUT_MIN_MV = -17'sd15000;

  // Quarter turn in Q30 radians and the Taylor series divisors (2k)(2k+1).
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam int unsigned TAYLOR_TERMS = 7;
  localparam logic [7:0] TAYLOR_DIV [TAYLOR_TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72,
                                                      8'd110, 8'd156, 8'd210};

endpackage

FILE: rtl/waveform_sample_generator.sv
// Waveform sample generator.
// A sample index arrives on the s_axis stream; the block forms the phase
// (index * phase_step + phase_shift) modulo one turn, evaluates the selected
// shape (sine, square, triangle, saw, inverse saw) and sends
// dc_offset_mv + amplitude_mv * wave, floored and limited to +/-15000 mV,
// on the m_axis stream. Each request gives exactly one result.
// Settings are written on the cfg channel (index, data); cfg_ready is always
// high and writes are meant to happen while the pipeline is empty.
// Pipeline: the five register stages (multiply, phase add, sine ROM read and
// shape select, amplitude multiply, offset add and limit) lie between the
// edge that accepts a request and its result on m_axis. Throughput is one
// sample per cycle while the receiver does not stall, since every stage
// takes a new sample whenever the pipeline advances.
// When the receiver stalls, every stage holds and s_axis_tready drops, so no
// sample is lost or repeated; bubbles in the pipeline are not squeezed out.
// Reset (rst, synchronous) empties the pipeline and loads the default
// settings: sine, step 655, offset 0, 1000 mV amplitude, 2500 mV DC, 50% duty.
// The sine ROM is a constant quarter-wave table built at elaboration.
module waveform_sample_generator
  import wsg_pkg::*;
#(
  parameter int unsigned PHASE_BITS     = 16,
  parameter int unsigned SINE_ADDR_BITS = 10,
  parameter int unsigned WAVE_FRAC_BITS = 15
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IDX_W-1:0]        s_axis_tdata,   // [15:0] sample_index
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [15:0]             m_axis_tdata,   // [14:0] voltage_mv, [15] zero
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int unsigned QBITS  = SINE_ADDR_BITS - 2;
  localparam int unsigned QSIZE  = 1 << QBITS;
  localparam int unsigned WAVE_W = WAVE_FRAC_BITS + 1;
  localparam int unsigned MUL_W  = IDX_W + STEP_W;
  localparam int unsigned EXT_W  = PHASE_BITS + SINE_ADDR_BITS;
  localparam int unsigned PROD_W = AMP_W + 1 + WAVE_W + 1;
  localparam logic [WAVE_W-1:0] ONE = WAVE_W'(1) << WAVE_FRAC_BITS;

  typedef logic [WAVE_W-1:0] sine_rom_t [QSIZE+1];

  // Quarter-wave sine magnitudes, from the Taylor series in Q30.
  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] v;
    for (int i = 0; i <= int'(QSIZE); i++) begin
      x    = (64'(i) * 64'(HALF_PI_Q30)) >> QBITS;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 64'd0;
      for (int k = 0; k < int'(TAYLOR_TERMS); k++) begin
        term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[k]);
        if ((k & 1) == 0) neg = neg + term;
        else              pos = pos + term;
      end
      s = (pos > neg) ? pos - neg : 64'd0;
      v = (s + (64'd1 << (29 - WAVE_FRAC_BITS))) >> (30 - WAVE_FRAC_BITS);
      if (v > 64'(ONE)) v = 64'(ONE);
      rom[i] = WAVE_W'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_Q = build_sine();

  // Configuration registers.
  logic [2:0]        wave_type;
  logic [STEP_W-1:0] phase_step;
  logic [STEP_W-1:0] phase_shift;
  logic [AMP_W-1:0]  amplitude_mv;
  logic [DC_W-1:0]   dc_offset_mv;
  logic [DUTY_W-1:0] duty_percent;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_type    <= RST_WAVE_TYPE;
      phase_step   <= RST_STEP;
      phase_shift  <= RST_OFFSET;
      amplitude_mv <= RST_AMP;
      dc_offset_mv <= RST_DC;
      duty_percent <= RST_DUTY;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WAVE_TYPE:    wave_type    <= cfg_data[2:0];
        REG_PHASE_STEP:   phase_step   <= cfg_data;
        REG_PHASE_SHIFT:  phase_shift  <= cfg_data;
        REG_AMPLITUDE:    amplitude_mv <= cfg_data[AMP_W-1:0];
        REG_DC_OFFSET:    dc_offset_mv <= cfg_data[DC_W-1:0];
        REG_DUTY:         duty_percent <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves together unless the output register is blocked.
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic                    v1, v2, v3, v4;
  logic [MUL_W-1:0]        mul1;
  logic [PHASE_BITS-1:0]   ph2;
  logic [WAVE_W-1:0]       rom3;
  logic [WAVE_W-1:0]       shape3;
  logic                    is_sine3;
  logic                    neg3;
  logic signed [PROD_W-1:0] prod4;
  logic [OUT_W-1:0]        voltage;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      v4            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1            <= s_axis_tvalid;
      v2            <= v1;
      v3            <= v2;
      v4            <= v3;
      m_axis_tvalid <= v4;
    end
  end

  // Stage 1: index times phase step.
  always_ff @(posedge clk) begin
    if (adv) mul1 <= MUL_W'(s_axis_tdata) * MUL_W'(phase_step);
  end

  // Stage 2: add the phase offset and wrap into one turn.
  logic [MUL_W:0] phase_sum;
  assign phase_sum = {1'b0, mul1} + (MUL_W+1)'(phase_shift);

  always_ff @(posedge clk) begin
    if (adv) ph2 <= phase_sum[PHASE_BITS-1:0];
  end

  // Stage 3: sine ROM address and the other shapes straight from the phase.
  logic [EXT_W-1:0]          ph_ext;
  logic [SINE_ADDR_BITS-1:0] sine_addr;
  logic [QBITS-1:0]          quarter_pos;
  logic [QBITS:0]            rom_idx;
  logic [PHASE_BITS+DUTY_W-1:0] ph_pct;
  logic [PHASE_BITS+DUTY_W-1:0] duty_lim;
  logic [PHASE_BITS-1:0]     tri_base;
  logic [PHASE_BITS+WAVE_W-1:0] tri_ext;
  logic [PHASE_BITS+WAVE_FRAC_BITS-1:0] saw_ext;
  logic [WAVE_FRAC_BITS-1:0] saw_val;
  logic [WAVE_W-1:0]         shape;

  always_comb begin
    ph_ext      = {ph2, {SINE_ADDR_BITS{1'b0}}};
    sine_addr   = ph_ext[EXT_W-1 -: SINE_ADDR_BITS];
    quarter_pos = sine_addr[QBITS-1:0];
    // Odd quarters run the table backwards.
    rom_idx     = sine_addr[QBITS] ? (QBITS+1)'(QSIZE) - {1'b0, quarter_pos}
                                   : {1'b0, quarter_pos};

    ph_pct   = (PHASE_BITS+DUTY_W)'(ph2) * (PHASE_BITS+DUTY_W)'(PERCENT_SCALE);
    duty_lim = {duty_percent, {PHASE_BITS{1'b0}}};

    // Triangle folds the second half turn back down.
    tri_base = ph2[PHASE_BITS-1] ? (~ph2 + PHASE_BITS'(1)) : ph2;
    tri_ext  = {tri_base, {WAVE_W{1'b0}}};
    saw_ext  = {ph2, {WAVE_FRAC_BITS{1'b0}}};
    saw_val  = saw_ext[PHASE_BITS+WAVE_FRAC_BITS-1:PHASE_BITS];

    case (wave_type)
      WAVE_SQUARE:   shape = (ph_pct < duty_lim) ? ONE : '0;
      WAVE_TRIANGLE: shape = tri_ext[PHASE_BITS+WAVE_W-1:PHASE_BITS];
      WAVE_SAW:      shape = {1'b0, saw_val};
      WAVE_INV_SAW:  shape = ONE - {1'b0, saw_val};
      default:       shape = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rom3     <= SINE_Q[rom_idx];
      shape3   <= shape;
      is_sine3 <= (wave_type == WAVE_SINE);
      neg3     <= sine_addr[SINE_ADDR_BITS-1];
    end
  end

  // Stage 4: signed wave value times amplitude.
  logic signed [WAVE_W:0] wave4;

  always_comb begin
    if (is_sine3) begin
      wave4 = neg3 ? -$signed({1'b0, rom3}) : $signed({1'b0, rom3});
    end else begin
      wave4 = $signed({1'b0, shape3});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod4 <= PROD_W'($signed({1'b0, amplitude_mv})) * PROD_W'(wave4);
    end
  end

  // Stage 5: floor by arithmetic shift, add DC offset and limit.
  logic signed [PROD_W-1:0] scaled;
  logic signed [15:0]       scaled_n;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  limited;

  always_comb begin
    scaled   = prod4 >>> WAVE_FRAC_BITS;
    scaled_n = scaled[15:0];
    sum      = SUM_W'($signed(dc_offset_mv)) + SUM_W'(scaled_n);
    if (sum > OUT_MAX_MV) begin
      limited = OUT_MAX_MV;
    end else if (sum < OUT_MIN_MV) begin
      limited = OUT_MIN_MV;
    end else begin
      limited = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) voltage <= limited[OUT_W-1:0];
  end

  assign m_axis_tdata = {1'b0, voltage};

endmodule

FILE: test/tb.sv
module tb;
  import wsg_pkg::*;

  // Predictor constants at the default build of the block.
  localparam int PH_BITS = 16;
  localparam int SINE_BITS = 10;
  localparam int FRAC_BITS = 15;
  localparam int TAYLOR_ORDER = 7;
  localparam int LATENCY = 5;
  localparam int LONG_HOLD = 300;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 85;
  localparam longint TIMEOUT_CYCLES = 200000;
  localparam logic [63:0] FULL_TURN = 64'd1 << PH_BITS;
  localparam logic [63:0] HALF_TURN = FULL_TURN >> 1;
  localparam logic [63:0] PHASE_MASK = FULL_TURN - 64'd1;
  localparam logic [63:0] QUARTER_SIZE = 64'd1 << (SINE_BITS - 2);
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_U = 64'd1 << FRAC_BITS;
  localparam longint ONE_LEVEL = 64'sd1 << FRAC_BITS;
  localparam logic [63:0] DUTY_SCALE = 64'd100;
  localparam longint OUT_HI = 15000;
  localparam longint OUT_LO = -15000;

  // Register indexes that decode to nothing, and a wave code with no shape.
  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;
  localparam logic [2:0] WAVE_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IDX_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Settings as the block should hold them.
  logic [2:0] cur_wave = RST_WAVE_TYPE;
  logic [15:0] cur_step = RST_STEP;
  logic [15:0] cur_offset = RST_OFFSET;
  logic [12:0] cur_amp = RST_AMP;
  logic signed [14:0] cur_dc = RST_DC;
  logic [6:0] cur_duty = RST_DUTY;

  logic [15:0] index_q[$];
  logic signed [14:0] volt_q[$];
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  bit src_pause = 1'b0;
  bit hold_go = 1'b0;
  bit rx_hold = 1'b0;
  int err_count = 0;

  waveform_sample_generator uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Signed sine level: quarter-wave angle in Q30 radians, truncated Taylor series,
  // rounded to the wave fraction, limited to one and negated in the second half turn.
  function automatic longint sine_level(input logic [SINE_BITS-1:0] addr);
    logic [1:0] quad;
    logic [63:0] r, idx, x, x2, term, pos, neg, s, v;
    int k;
    quad = addr[SINE_BITS-1 -: 2];
    r = 64'(addr[SINE_BITS-3:0]);
    idx = quad[0] ? QUARTER_SIZE - r : r;
    x = (idx * QUARTER_TURN_Q30) >> (SINE_BITS - 2);
    x2 = (x * x) >> 30;
    term = x;
    pos = x;
    neg = 64'd0;
    for (k = 1; k <= TAYLOR_ORDER; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) neg += term;
      else pos += term;
    end
    s = (pos > neg) ? pos - neg : 64'd0;
    v = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (v > ONE_U) v = ONE_U;
    return quad[1] ? -longint'(v) : longint'(v);
  endfunction

  // Expected output voltage for one sample index under the current settings.
  function automatic logic [14:0] predict_voltage(input logic [15:0] sample);
    logic [63:0] phase, tri_dist;
    longint level, amp, prod, scaled, dc, volts;
    phase = (64'(sample) * 64'(cur_step) + 64'(cur_offset)) & PHASE_MASK;
    case (cur_wave)
      WAVE_SINE: level = sine_level(phase[PH_BITS-1 -: SINE_BITS]);
      WAVE_SQUARE: level = (phase * DUTY_SCALE < (64'(cur_duty) << PH_BITS)) ? ONE_LEVEL : 0;
      WAVE_TRIANGLE: begin
        tri_dist = (phase < HALF_TURN) ? phase : FULL_TURN - phase;
        level = longint'((tri_dist << (FRAC_BITS + 1)) >> PH_BITS);
      end
      WAVE_SAW: level = longint'((phase << FRAC_BITS) >> PH_BITS);
      WAVE_INV_SAW: level = ONE_LEVEL - longint'((phase << FRAC_BITS) >> PH_BITS);
      default: level = 0;
    endcase
    amp = longint'(cur_amp);
    prod = amp * level;
    // Arithmetic shift floors negative products.
    scaled = prod >>> FRAC_BITS;
    dc = longint'(cur_dc);
    volts = dc + scaled;
    if (volts > OUT_HI) volts = OUT_HI;
    if (volts < OUT_LO) volts = OUT_LO;
    return volts[14:0];
  endfunction

  // Sender: offers queued sample indexes and records the expected voltage of
  // every accepted request.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) volt_q.push_back(predict_voltage(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (index_q.size() != 0 && !src_pause && $urandom_range(0, 99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= index_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted in cycles once the stimulus asks for it.
  initial begin : long_hold
    wait (hold_go);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    rx_hold = 1'b0;
  end

  // Receiver: compares each accepted voltage with the oldest expectation.
  always @(posedge clk) begin : receiver
    logic signed [14:0] exp_mv;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (volt_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected voltage, expected none, actual %0d", $time,
                   $signed(m_axis_tdata[14:0]));
        end else begin
          exp_mv = volt_q.pop_front();
          if (m_axis_tdata[14:0] !== exp_mv) begin
            err_count++;
            $display("%0t: voltage_mv mismatch, expected %0d, actual %0d", $time, exp_mv,
                     $signed(m_axis_tdata[14:0]));
          end
        end
      end
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
      end
    end
  end

  // One register write; the expected settings follow the accepted write.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WAVE_TYPE: cur_wave = value[2:0];
      REG_PHASE_STEP: cur_step = value;
      REG_PHASE_SHIFT: cur_offset = value;
      REG_AMPLITUDE: cur_amp = value[12:0];
      REG_DC_OFFSET: cur_dc = value[14:0];
      REG_DUTY: cur_duty = value[6:0];
      default: ;
    endcase
  endtask

  // Wait until every request has been sent and answered, then let the
  // pipeline settle.
  task automatic wait_idle();
    while (index_q.size() != 0 || s_axis_tvalid || volt_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  task automatic send_index(input logic [15:0] value);
    @(negedge clk);
    index_q.push_back(value);
  endtask

  // Register value: half the time in range, otherwise all zeros, all ones or raw bits.
  function automatic logic [15:0] pick_value(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  function automatic logic [15:0] pick_wave();
    logic [2:0] code;
    if ($urandom_range(0, 7) == 0) code = 3'(WAVE_INV_SAW + 1 + $urandom_range(0, 2));
    else code = 3'($urandom_range(WAVE_SINE, WAVE_INV_SAW));
    return {13'($urandom()), code};
  endfunction

  // Random settings for one phase; the first two phases use all-zero and
  // all-one words.
  task automatic load_settings(input int phase_num);
    if (phase_num == 0) begin
      write_reg(REG_WAVE_TYPE, 16'h0000);
      write_reg(REG_PHASE_STEP, 16'h0000);
      write_reg(REG_PHASE_SHIFT, 16'h0000);
      write_reg(REG_AMPLITUDE, 16'h0000);
      write_reg(REG_DC_OFFSET, 16'h0000);
      write_reg(REG_DUTY, 16'h0000);
    end else if (phase_num == 1) begin
      write_reg(REG_WAVE_TYPE, 16'hFFFF);
      write_reg(REG_PHASE_STEP, 16'hFFFF);
      write_reg(REG_PHASE_SHIFT, 16'hFFFF);
      write_reg(REG_AMPLITUDE, 16'hFFFF);
      write_reg(REG_DC_OFFSET, 16'hFFFF);
      write_reg(REG_DUTY, 16'hFFFF);
    end else begin
      write_reg(REG_WAVE_TYPE, pick_wave());
      write_reg(REG_PHASE_STEP, pick_value(0, 65535));
      write_reg(REG_PHASE_SHIFT, pick_value(0, 65535));
      write_reg(REG_AMPLITUDE, pick_value(0, 5000));
      write_reg(REG_DC_OFFSET, pick_value(-10000, 10000));
      write_reg(REG_DUTY, pick_value(0, 100));
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, 16'($urandom()));
    end
  endtask

  // Stimulus: directed checks first, then random phases under changing settings.
  initial begin : stimulus
    logic [2:0] sweep_waves[6];
    logic [15:0] sweep_pts[3];
    int p, i, guard;
    sweep_waves = '{WAVE_SINE, WAVE_SQUARE, WAVE_TRIANGLE, WAVE_SAW, WAVE_INV_SAW, WAVE_UNUSED};
    sweep_pts = '{16'd0, 16'd32768, 16'd49151};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct = 20;
    dst_idle_pct = 62;

    // Settings straight out of reset.
    send_index(16'd0);
    send_index(16'd1);
    send_index(16'hFFFF);
    send_index(16'd32768);
    wait_idle();

    // Every shape at phase zero, half a turn and just under three quarters.
    write_reg(REG_PHASE_STEP, 16'd1);
    write_reg(REG_PHASE_SHIFT, 16'd0);
    write_reg(REG_AMPLITUDE, 16'd5000);
    write_reg(REG_DC_OFFSET, 16'd0);
    for (i = 0; i < 6; i++) begin
      write_reg(REG_WAVE_TYPE, {13'd0, sweep_waves[i]});
      send_index(sweep_pts[0]);
      send_index(sweep_pts[1]);
      send_index(sweep_pts[2]);
      wait_idle();
    end

    // Square with zero duty, then duty above one hundred with upper bits set.
    write_reg(REG_WAVE_TYPE, {13'd0, WAVE_SQUARE});
    write_reg(REG_DUTY, 16'd0);
    send_index(16'd12345);
    wait_idle();
    write_reg(REG_DUTY, 16'hFF7F);
    send_index(16'd12345);
    wait_idle();

    // Saturation at both ends; writes to unknown indexes must change nothing.
    write_reg(REG_WAVE_TYPE, 16'hFFF8 | WAVE_SAW);
    write_reg(REG_AMPLITUDE, 16'hFFFF);
    write_reg(REG_DC_OFFSET, 16'h3FFF);
    write_reg(REG_UNUSED_LO, 16'hFFFF);
    write_reg(REG_UNUSED_HI, 16'h0000);
    send_index(16'hFFFF);
    wait_idle();
    write_reg(REG_WAVE_TYPE, {13'd0, WAVE_SINE});
    write_reg(REG_DC_OFFSET, 16'h4000);
    send_index(16'd49152);
    wait_idle();

    // Random phases.
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p < NUM_PHASES / 3) begin
        src_idle_pct = 20;
        dst_idle_pct = 62;
      end else if (p < 2 * NUM_PHASES / 3) begin
        src_idle_pct = 62;
        dst_idle_pct = 20;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      load_settings(p);
      @(negedge clk);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 3) == 0) index_q.push_back(16'($urandom_range(0, 15)));
        else index_q.push_back(16'($urandom_range(0, 65535)));
      end
      // Receiver holds off long enough for the pipeline to back up.
      if (p == NUM_PHASES - 3) hold_go = 1'b1;
      // Sender stops mid-phase until every result is back.
      if (p == 5 || p == NUM_PHASES - 2) begin
        while (index_q.size() > PHASE_ITEMS / 2) @(negedge clk);
        src_pause = 1'b1;
        while (s_axis_tvalid || volt_q.size() != 0) @(negedge clk);
        src_pause = 1'b0;
      end
      if (p < NUM_PHASES - 1) wait_idle();
    end

    // Final drain with a bound; anything left over is a failure.
    for (guard = 0; guard < 10000 && (index_q.size() != 0 || s_axis_tvalid || volt_q.size() != 0);
         guard++)
      @(negedge clk);
    if (volt_q.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected voltages never arrived", $time, volt_q.size());
    end
    repeat (LATENCY + 3) @(negedge clk);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("tb failed");
    $finish;
  end

endmodule
